// ===== hw/rtl/spv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice package
// Shared command and register codes, queue control type and rate constants.
// ----------------------------------------------------------------------------
package spv_pkg;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_NOTE_ON = 2'd1,
        CMD_LOAD    = 2'd2
    } cmd_t;

    typedef enum logic {
        REG_SAMPLE_COUNT = 1'b0,
        REG_MONO_SOURCE  = 1'b1
    } cfg_reg_t;

    localparam int CFG_DATA_W  = 15;
    localparam int COUNT_W     = 15;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam int RATE_ONE    = 65536;
    localparam int RATE_STEP   = 6554;
    localparam int NOTE_CENTER = 60;
    localparam int HALF_FRAME  = 32768;

    typedef struct packed {
        logic is_load;
        logic zero;
        logic mono;
    } op_ctrl_t;

    function automatic logic signed [23:0] note_rate(input logic [6:0] note);
        return 24'(RATE_ONE + (int'(note) - NOTE_CENTER) * RATE_STEP);
    endfunction

endpackage

// ===== hw/rtl/spv_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/spv_front.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice front end
// Accepts items, runs the phase accumulator and queues store operations.
// ----------------------------------------------------------------------------
module spv_front #(
    parameter int MAX_FRAMES  = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    command,
    input  logic [6:0]                    midi_note,
    input  logic [13:0]                   load_index,
    input  logic signed [15:0]            load_left,
    input  logic signed [15:0]            load_right,
    input  logic [14:0]                   sample_count,
    input  logic                          mono_source,
    input  logic                          q_full,
    output logic                          push,
    output spv_pkg::op_ctrl_t             push_ctrl,
    output logic [$clog2(MAX_FRAMES)-1:0] push_addr,
    output logic [SAMPLE_BITS-1:0]        push_left,
    output logic [SAMPLE_BITS-1:0]        push_right
);

    import spv_pkg::*;

    localparam int AW      = $clog2(MAX_FRAMES);
    localparam int CNT_MAX = (MAX_FRAMES < 32767) ? MAX_FRAMES : 32767;

    logic signed [31:0] ptr_reg,  ptr_next;
    logic signed [23:0] rate_reg, rate_next;

    logic [COUNT_W-1:0] count;
    logic [31:0]        limit;
    logic               accept;
    logic               note_on;
    logic               is_tick;
    logic               load_ok;
    logic signed [23:0] rate_eff;
    logic signed [31:0] ptr_cur;
    logic [31:0]        ptr_base;
    logic [31:0]        idx_sum;
    logic [15:0]        idx;
    logic               idx_out;
    logic signed [32:0] adv;
    logic [31:0]        ptr_sat;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    assign count = (sample_count > COUNT_W'(CNT_MAX)) ? COUNT_W'(CNT_MAX) : sample_count;
    assign limit = {1'b0, count, 16'b0};

    assign note_on  = (cmd_t'(command) == CMD_NOTE_ON);
    assign load_ok  = (32'(load_index) < 32'(MAX_FRAMES));
    assign rate_eff = note_on ? note_rate(midi_note) : rate_reg;
    assign ptr_cur  = note_on ? 32'sd0 : ptr_reg;
    assign ptr_base = ptr_cur[31] ? limit : ptr_cur;
    assign idx_sum  = ptr_base + 32'(HALF_FRAME);
    assign idx      = idx_sum[31:16];
    assign idx_out  = (idx >= {1'b0, count});
    assign adv      = $signed({1'b0, ptr_base}) + 33'(rate_eff);
    assign ptr_sat  = (adv > $signed({1'b0, limit})) ? limit : adv[31:0];

    always_comb
    begin
        is_tick            = 1'b0;
        push               = 1'b0;
        push_ctrl.is_load  = 1'b0;
        push_ctrl.zero     = 1'b1;
        push_ctrl.mono     = mono_source;
        push_addr          = AW'(load_index);
        push_left          = SAMPLE_BITS'(load_left);
        push_right         = SAMPLE_BITS'(load_right);
        unique case (cmd_t'(command)) inside
            CMD_TICK, CMD_NOTE_ON:
            begin
                is_tick        = accept && (count != '0);
                push           = accept;
                push_ctrl.zero = (count == '0) || idx_out;
                push_addr      = AW'(idx);
            end
            CMD_LOAD:
            begin
                push              = accept && load_ok;
                push_ctrl.is_load = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ptr_next  = ptr_reg;
        rate_next = rate_reg;
        if (is_tick)
        begin
            ptr_next  = ptr_sat;
            rate_next = rate_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            rate_reg <= 24'(RATE_ONE);
        end
        else
        begin
            ptr_reg  <= ptr_next;
            rate_reg <= rate_next;
        end
    end

endmodule

// ===== hw/rtl/spv_queue.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice operation queue
// Short FIFO that decouples the front end from the store and output stage.
// ----------------------------------------------------------------------------
module spv_queue #(
    parameter int DATA_W = 46
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  spv_pkg::op_ctrl_t push_ctrl,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    output logic              valid,
    input  logic              pop,
    output spv_pkg::op_ctrl_t head_ctrl,
    output logic [DATA_W-1:0] head_data
);

    import spv_pkg::*;

    op_ctrl_t          ctrl_mem [QUEUE_DEPTH];
    logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   cnt_reg,    cnt_next;

    assign full      = (cnt_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid     = (cnt_reg != '0);
    assign head_ctrl = ctrl_mem[rd_ptr_reg];
    assign head_data = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctrl_mem[wr_ptr_reg] <= push_ctrl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/spv_back.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice back end
// Carries out store writes and reads and holds the output sample register.
// ----------------------------------------------------------------------------
module spv_back #(
    parameter int MAX_FRAMES  = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  spv_pkg::op_ctrl_t             op_ctrl,
    input  logic [$clog2(MAX_FRAMES)-1:0] op_addr,
    input  logic [SAMPLE_BITS-1:0]        op_left,
    input  logic [SAMPLE_BITS-1:0]        op_right,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [15:0]            left_out,
    output logic signed [15:0]            right_out
);

    import spv_pkg::*;

    logic                   rd_valid_reg,  rd_valid_next;
    logic                   rd_zero_reg;
    logic                   rd_mono_reg;
    logic                   out_valid_reg, out_valid_next;
    logic signed [15:0]     left_out_reg;
    logic signed [15:0]     right_out_reg;

    logic                   out_free;
    logic                   ram_we;
    logic                   ram_re;
    logic [SAMPLE_BITS-1:0] l_rdata;
    logic [SAMPLE_BITS-1:0] r_rdata;

    assign out_free = !out_valid_reg || out_ready;
    assign q_pop    = q_valid && (!rd_valid_reg || out_free);
    assign ram_we   = q_pop && op_ctrl.is_load;
    assign ram_re   = q_pop && !op_ctrl.is_load && !op_ctrl.zero;

    spv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_left_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_addr),
        .wdata (op_left),
        .re    (ram_re),
        .raddr (op_addr),
        .rdata (l_rdata)
    );

    spv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_FRAMES)
    ) u_right_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (op_addr),
        .wdata (op_right),
        .re    (ram_re),
        .raddr (op_addr),
        .rdata (r_rdata)
    );

    always_comb
    begin
        rd_valid_next  = rd_valid_reg;
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            rd_valid_next  = 1'b0;
            out_valid_next = rd_valid_reg;
        end
        if (q_pop)
        begin
            rd_valid_next = !op_ctrl.is_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            rd_zero_reg <= op_ctrl.zero;
            rd_mono_reg <= op_ctrl.mono;
        end
        if (out_free && rd_valid_reg)
        begin
            left_out_reg  <= rd_zero_reg ? 16'sd0 : 16'(l_rdata);
            right_out_reg <= rd_zero_reg ? 16'sd0 :
                             (rd_mono_reg ? 16'(l_rdata) : 16'(r_rdata));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

// ===== hw/rtl/sample_playback_voice.sv =====
// ----------------------------------------------------------------------------
// Sample playback voice
// One-voice stereo sample player with a Q16.16 phase accumulator.
// ----------------------------------------------------------------------------
// Input items arrive on in_valid/in_ready. A load item writes one frame into
// the left and right sample stores; a tick item, with or without note-on,
// yields one stereo item on out_valid/out_ready. Other commands are taken
// and dropped. Configuration is written through cfg_write, cfg_index and
// cfg_data; the user must do so only while the block is idle, which the
// block itself does not enforce. A tick result passes through the queue,
// the store read and output registers. One item is accepted per cycle while
// the queue is not full; the front end updates the pointer and each store
// has one write and one read port, so loads and ticks mix freely.
// A four-entry queue sits between the front end and the store stage. When
// the receiver stalls, the output register holds its item, the store stage
// stops, the queue fills and in_ready then falls.
// Reset clears the pointer, sets the rate to one, clears both registers and
// empties the queue. The sample stores are not cleared.
// ----------------------------------------------------------------------------
module sample_playback_voice #(
    parameter int MAX_FRAMES  = 16384,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      command,
    input  logic [6:0]                      midi_note,
    input  logic [13:0]                     load_index,
    input  logic signed [15:0]              load_left,
    input  logic signed [15:0]              load_right,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [15:0]              left_out,
    output logic signed [15:0]              right_out,
    input  logic                            cfg_write,
    input  logic                            cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import spv_pkg::*;

    localparam int AW     = $clog2(MAX_FRAMES);
    localparam int DATA_W = AW + 2 * SAMPLE_BITS;

    logic [COUNT_W-1:0]     sample_count_reg, sample_count_next;
    logic                   mono_source_reg,  mono_source_next;

    logic                   push;
    op_ctrl_t               push_ctrl;
    logic [AW-1:0]          push_addr;
    logic [SAMPLE_BITS-1:0] push_left;
    logic [SAMPLE_BITS-1:0] push_right;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    op_ctrl_t               head_ctrl;
    logic [DATA_W-1:0]      head_data;

    always_comb
    begin
        sample_count_next = sample_count_reg;
        mono_source_next  = mono_source_reg;
        if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SAMPLE_COUNT: sample_count_next = cfg_data[COUNT_W-1:0];
                REG_MONO_SOURCE:  mono_source_next  = cfg_data[0];
                default:          sample_count_next = sample_count_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            mono_source_reg  <= 1'b0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            mono_source_reg  <= mono_source_next;
        end
    end

    spv_front #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .midi_note    (midi_note),
        .load_index   (load_index),
        .load_left    (load_left),
        .load_right   (load_right),
        .sample_count (sample_count_reg),
        .mono_source  (mono_source_reg),
        .q_full       (q_full),
        .push         (push),
        .push_ctrl    (push_ctrl),
        .push_addr    (push_addr),
        .push_left    (push_left),
        .push_right   (push_right)
    );

    spv_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ctrl (push_ctrl),
        .push_data ({push_addr, push_left, push_right}),
        .full      (q_full),
        .valid     (q_valid),
        .pop       (q_pop),
        .head_ctrl (head_ctrl),
        .head_data (head_data)
    );

    spv_back #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .op_ctrl   (head_ctrl),
        .op_addr   (head_data[DATA_W-1 -: AW]),
        .op_left   (head_data[2*SAMPLE_BITS-1 -: SAMPLE_BITS]),
        .op_right  (head_data[SAMPLE_BITS-1:0]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Queue popped while empty.");

    a_tick_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready &&
         (command == CMD_TICK || command == CMD_NOTE_ON)) |-> push)
        else $error("Accepted tick item was not queued.");

    a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(q_pop, 2))
        else $error("Output item appeared without a queued read.");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sample playback voice testbench
// Feeds load, tick, note-on and reserved items to the voice with random input gaps and
// output stalls. A scoreboard keeps its own sample store, play pointer and
// rate, works out the stereo output of every accepted tick and checks the
// output items in order. Sample count and mono mode change between phases
// only, once the voice is idle. Every frame is loaded before a tick reads it.
// ----------------------------------------------------------------------------

module tb;

    import spv_pkg::*;

    localparam int STORE_FRAMES = 16384;

    class voice_scoreboard;

        typedef struct packed {
            logic [15:0] left_s;
            logic [15:0] right_s;
        } frame_t;

        logic [15:0] left_mem  [STORE_FRAMES];
        logic [15:0] right_mem [STORE_FRAMES];
        int          pointer   = 0;
        int          rate      = RATE_ONE;
        int          count_reg = 0;
        bit          mono_reg  = 1'b0;
        frame_t      expected_q[$];
        int          checked   = 0;
        int          nonzero   = 0;
        int          errors    = 0;

        function void set_config(cfg_reg_t which, logic [CFG_DATA_W-1:0] value);
            if (which == REG_SAMPLE_COUNT)
                count_reg = int'(value);
            else
                mono_reg = value[0];
        endfunction

        function int peek_slot(logic [1:0] cmd, logic [6:0] note);
            longint frames;
            longint pos;
            longint slot;
            frames = (count_reg > STORE_FRAMES) ? STORE_FRAMES : count_reg;
            if (frames == 0 || !(cmd == CMD_TICK || cmd == CMD_NOTE_ON))
                return -1;
            pos = (cmd == CMD_NOTE_ON) ? 0 : pointer;
            if (pos < 0)
                pos = frames << 16;
            slot = (pos + HALF_FRAME) >>> 16;
            if (slot >= frames)
                return -1;
            return int'(slot);
        endfunction

        function void note_input(logic [1:0] cmd, logic [6:0] note, logic [13:0] index,
                                 logic [15:0] left_in, logic [15:0] right_in);
            longint frames;
            longint limit;
            longint pos;
            longint slot;
            frame_t result;
            result = '0;
            if (cmd == CMD_LOAD)
            begin
                left_mem[index]  = left_in;
                right_mem[index] = right_in;
            end
            else if (cmd == CMD_TICK || cmd == CMD_NOTE_ON)
            begin
                frames = (count_reg > STORE_FRAMES) ? STORE_FRAMES : count_reg;
                if (frames != 0)
                begin
                    if (cmd == CMD_NOTE_ON)
                    begin
                        pointer = 0;
                        rate    = RATE_ONE + (int'(note) - NOTE_CENTER) * RATE_STEP;
                    end
                    limit = frames << 16;
                    pos   = pointer;
                    if (pos < 0)
                        pos = limit;
                    slot = (pos + HALF_FRAME) >>> 16;
                    if (slot < frames)
                    begin
                        result.left_s  = left_mem[slot];
                        result.right_s = mono_reg ? left_mem[slot] : right_mem[slot];
                    end
                    pos = pos + rate;
                    if (pos > limit)
                        pos = limit;
                    pointer = int'(pos);
                end
                expected_q.push_back(result);
            end
        endfunction

        function void check_result(logic [15:0] left_got, logic [15:0] right_got);
            frame_t want;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR at %0t: unexpected output item left %0d right %0d",
                             $time, $signed(left_got), $signed(right_got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (want != '0)
                nonzero++;
            if (want.left_s !== left_got || want.right_s !== right_got)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR at %0t: expected left %0d right %0d, got left %0d right %0d",
                             $time, $signed(want.left_s), $signed(want.right_s),
                             $signed(left_got), $signed(right_got));
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

    endclass

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int         COUNT_MAX    = (1 << COUNT_W) - 1;

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_ready;
    logic [1:0]            command    = CMD_TICK;
    logic [6:0]            midi_note  = '0;
    logic [13:0]           load_index = '0;
    logic signed [15:0]    load_left  = '0;
    logic signed [15:0]    load_right = '0;
    logic                  out_valid;
    logic                  out_ready  = 1'b0;
    logic signed [15:0]    left_out;
    logic signed [15:0]    right_out;
    logic                  cfg_write  = 1'b0;
    logic                  cfg_index  = REG_SAMPLE_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    voice_scoreboard frame_check = new();
    bit              store_written [STORE_FRAMES];
    int              gap_pct    = 0;
    int              stall_pct  = 0;
    int              n_ticks    = 0;
    int              n_notes    = 0;
    int              n_loads    = 0;
    int              n_dropped  = 0;
    int              n_phases   = 0;
    int              stim_items = 0;

    sample_playback_voice dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .midi_note  (midi_note),
        .load_index (load_index),
        .load_left  (load_left),
        .load_right (load_right),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .left_out   (left_out),
        .right_out  (right_out),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always
    begin
        @(negedge clk);
        if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct)
        begin
            out_ready = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        out_ready = 1'b1;
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            frame_check.check_result(left_out, right_out);

    task automatic send_item(input logic [1:0] cmd, input logic [6:0] note,
                             input logic [13:0] index, input logic [15:0] left_in,
                             input logic [15:0] right_in);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid   = 1'b1;
        command    = cmd;
        midi_note  = note;
        load_index = index;
        load_left  = left_in;
        load_right = right_in;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        frame_check.note_input(cmd, note, index, left_in, right_in);
        stim_items++;
        if (cmd == CMD_LOAD)
        begin
            store_written[index] = 1'b1;
            n_loads++;
        end
        else if (cmd == CMD_TICK)
            n_ticks++;
        else if (cmd == CMD_NOTE_ON)
            n_notes++;
        else
            n_dropped++;
        @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t which, input logic [CFG_DATA_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = which;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
        frame_check.set_config(which, value);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (frame_check.pending() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic fill_store(input int frames);
        for (int i = 0; i < frames; i++)
            if (!store_written[i])
                send_item(CMD_LOAD, 7'($urandom), 14'(i), 16'($urandom), 16'($urandom));
    endtask

    function automatic int pick_count(input int phase);
        int sel;
        sel = $urandom_range(0, 99);
        if (phase == 0)
            return STORE_FRAMES;
        if (phase == 1)
            return COUNT_MAX;
        if (phase == 2)
            return 1;
        if (sel < 8)
            return 0;
        if (sel < 70)
            return $urandom_range(1, 32);
        if (sel < 85)
            return $urandom_range(33, 600);
        if (sel < 93)
            return $urandom_range(601, STORE_FRAMES - 1);
        return $urandom_range(STORE_FRAMES, COUNT_MAX);
    endfunction

    initial
    begin
        int          frames;
        int          sel;
        int          slot;
        logic [1:0]  cmd;
        logic [6:0]  note;
        logic [13:0] index;

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // With a count of zero the voice is silent and ignores note-on.
        gap_pct   = 10;
        stall_pct = 10;
        send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_NOTE_ON, 7'd127, 14'h3FFF, 16'hFFFF, 16'hFFFF);
        send_item(CMD_RESERVED, 7'h7F, 14'h3FFF, 16'h8000, 16'h7FFF);
        wait_idle();
        write_reg(REG_SAMPLE_COUNT, 15'd4);
        write_reg(REG_MONO_SOURCE, 15'd0);
        send_item(CMD_LOAD, 7'd0, 14'd0, 16'h7FFF, 16'h8000);
        send_item(CMD_LOAD, 7'd0, 14'd1, 16'h8000, 16'h7FFF);
        send_item(CMD_LOAD, 7'd0, 14'd2, 16'h0000, 16'hFFFF);
        send_item(CMD_LOAD, 7'd0, 14'd3, 16'h5555, 16'hAAAA);
        send_item(CMD_LOAD, 7'd0, 14'h3FFF, 16'hAAAA, 16'h5555);

        // Unit rate runs off the end, then fast, reverse, near-stop and half rates.
        send_item(CMD_NOTE_ON, 7'd60, 14'd0, 16'h0000, 16'h0000);
        repeat (4) send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_NOTE_ON, 7'd127, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_NOTE_ON, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_NOTE_ON, 7'd45, 14'd0, 16'h0000, 16'h0000);
        repeat (3) send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_NOTE_ON, 7'd50, 14'd0, 16'h0000, 16'h0000);
        send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);
        wait_idle();
        write_reg(REG_MONO_SOURCE, 15'd1);
        send_item(CMD_NOTE_ON, 7'd55, 14'd0, 16'h0000, 16'h0000);
        repeat (2) send_item(CMD_TICK, 7'd0, 14'd0, 16'h0000, 16'h0000);

        while (stim_items < 1300)
        begin
            wait_idle();
            if (stim_items >= 1100)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            else
            begin
                gap_pct   = 12 * $urandom_range(0, 2);
                stall_pct = 12 * $urandom_range(0, 2);
            end
            frames = pick_count(n_phases);
            write_reg(REG_SAMPLE_COUNT, 15'(frames));
            write_reg(REG_MONO_SOURCE, 15'($urandom_range(0, 1)));
            if (frames > STORE_FRAMES)
                frames = STORE_FRAMES;
            if (frames <= 32)
                fill_store(frames);
            repeat ($urandom_range(40, 120))
            begin
                sel   = $urandom_range(0, 99);
                index = 14'($urandom);
                if (frames != 0 && $urandom_range(0, 1) == 1)
                    index = 14'($urandom_range(0, frames - 1));
                note = ($urandom_range(0, 1) == 1) ? 7'($urandom) : 7'($urandom_range(42, 84));
                if (sel < 70)
                    cmd = CMD_TICK;
                else if (sel < 80)
                    cmd = CMD_NOTE_ON;
                else if (sel < 96)
                    cmd = CMD_LOAD;
                else
                    cmd = CMD_RESERVED;
                if (cmd == CMD_TICK || cmd == CMD_NOTE_ON)
                begin
                    slot = frame_check.peek_slot(cmd, note);
                    if (slot >= 0 && !store_written[slot])
                        send_item(CMD_LOAD, 7'($urandom), 14'(slot),
                                  16'($urandom), 16'($urandom));
                end
                send_item(cmd, note, index, 16'($urandom), 16'($urandom));
            end
            n_phases++;
        end

        wait_idle();
        repeat (20) @(negedge clk);
        $display("Run covered %0d ticks, %0d note-ons, %0d loads and %0d dropped items",
                 n_ticks, n_notes, n_loads, n_dropped);
        $display("over %0d phases; %0d output items checked, %0d nonzero, %0d errors.",
                 n_phases, frame_check.checked, frame_check.nonzero, frame_check.errors);
        if (frame_check.errors == 0 && frame_check.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #8000000;
        $display("Timeout with %0d output items still outstanding.", frame_check.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
